/* hdl/lsac_pkg.sv */
// Package for the line sensor array classifier.
// Holds the field widths, the sequencer state type, the class codes and the
// divider status struct. It depends on nothing else.
package lsac_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int THRESH_BITS  = 10;
   localparam int IDX_BITS     = $clog2(SENSOR_COUNT);
   localparam int TIME_BITS    = 32;

   // Weighted sum: sample * index * 1000, summed over all sensors.
   localparam int WEIGHT_BITS  = 13;
   localparam int WSUM_BITS    = 25;
   localparam int SUM_BITS     = 13;
   localparam int QUOT_BITS    = 13;

   localparam int POS_SCALE    = 1000;
   localparam int DWELL_MS     = 150;
   localparam int BLACK_OFFSET = 50;

   localparam int REQ_DATA_BITS = 120;
   localparam int RSP_DATA_BITS = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } seq_state_type;

   typedef enum logic [2:0] {
      CLASS_CENTRE    = 3'd0,
      CLASS_LEFT      = 3'd1,
      CLASS_RIGHT     = 3'd2,
      CLASS_TJUNCTION = 3'd3,
      CLASS_NOLINE    = 3'd4
   } line_class_type;

   // Status that the divider reports back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Position weight of one sensor: its index times the position scale.
   function automatic logic [WEIGHT_BITS-1:0] idx_weight(input logic [IDX_BITS-1:0] idx);
      logic [31:0] w;
      w = 32'(idx) * 32'(POS_SCALE);
      return w[WEIGHT_BITS-1:0];
   endfunction

endpackage

/* hdl/lsac_divider.sv */
// Iterative restoring divider for the centroid quotient.
// One quotient bit per cycle; the quotient is known to fit in QUOT_BITS.
// Depends on lsac_pkg.
module lsac_divider
   import lsac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WSUM_BITS-1:0]  dividend,
   input  logic [SUM_BITS-1:0]   divisor,
   output div_status_type        status,
   output logic [QUOT_BITS-1:0]  quotient
);

   localparam int CNT_BITS = $clog2(QUOT_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUOT_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [SUM_BITS-1:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]  shift_ff, shift_in;
   logic [SUM_BITS-1:0]   dvsr_ff, dvsr_in;
   logic [SUM_BITS:0]     trial;
   logic                  fits;

   // Trial subtraction: shift in the next dividend bit and compare.
   assign trial = {rem_ff, shift_ff[QUOT_BITS-1]};
   assign fits  = trial >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         // The upper dividend bits start as the partial remainder.
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = SUM_BITS'(dividend[WSUM_BITS-1:QUOT_BITS]);
         shift_in = dividend[QUOT_BITS-1:0];
         dvsr_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = SUM_BITS'(trial - {1'b0, dvsr_ff});
         end else begin
            rem_in = trial[SUM_BITS-1:0];
         end
         shift_in = {shift_ff[QUOT_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      dvsr_ff  <= dvsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff;

endmodule

/* hdl/line_sensor_array_classifier.sv */
// Line sensor array classifier: weighted centroid, black-square dwell and
// turn class of one scan. Uses lsac_pkg and lsac_divider.
//
// Usage: a request on req_* carries one scan of eight samples, the
// millisecond time and the motion-complete flag. Each request yields exactly
// one response on rsp_* with the centroid, the no-signal flag, the latched
// class and the sticky black-square flag. Thresholds are written on csr_*
// only while the block is idle: the user's duty, not enforced by the block.
// A threshold write takes effect at the clock edge. After a request is
// accepted, the sequencer walks the scan one sensor a cycle through a single
// multiply-accumulate, loads the divider, runs the restoring divider (13
// quotient bits, then its done flag) and commits the response. One request is
// in work at a time and the input is ready again right after the commit.
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls, the following scan finishes its work and
// then waits in the sequencer until the output register is free.
// Reset (synchronous, active high) sets all thresholds to 512, clears the
// dwell tracker, the black-square flag and the class (centre), and drops
// the response valid.
module line_sensor_array_classifier
   import lsac_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // From bit 0: sample_0 .. sample_7 (10 each), now_ms (32), motion_done (1), zero pad.
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // From bit 0: centroid (13), no_signal (1), line_class (3), black_square (1), zero pad.
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // Threshold write port.
   input  logic                      csr_we,
   input  logic [IDX_BITS-1:0]       csr_addr,
   input  logic [THRESH_BITS-1:0]    csr_wdata
);

   localparam int NOW_LSB    = SENSOR_COUNT * SAMPLE_BITS;
   localparam int MOTION_BIT = NOW_LSB + TIME_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SENSOR_COUNT - 1);

   seq_state_type              state_ff, state_in;
   logic [THRESH_BITS-1:0]     thresh_ff [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0]     sample_ff [SENSOR_COUNT];
   logic [TIME_BITS-1:0]       now_ff;
   logic                       motion_ff;
   logic [IDX_BITS-1:0]        idx_ff, idx_in;
   logic [WSUM_BITS-1:0]       wsum_ff, wsum_in;
   logic [SUM_BITS-1:0]        sum_ff, sum_in;
   logic [SENSOR_COUNT-1:0]    above_ff, below_ff, black_ff;
   logic                       dwell_armed_ff;
   logic [TIME_BITS-1:0]       dwell_start_ff;
   logic                       black_seen_ff;
   line_class_type             class_ff, class_in;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0]   rsp_data_ff;

   // Sequencer controls.
   logic                       take_req;
   logic                       acc_en;
   logic                       div_start;
   logic                       commit;
   logic                       out_free;

   // Shared accumulate unit.
   logic [SAMPLE_BITS-1:0]     cur_sample;
   logic [THRESH_BITS-1:0]     cur_thresh;
   logic [SAMPLE_BITS+WEIGHT_BITS-1:0] product;

   // Divider link.
   div_status_type             div_status;
   logic [QUOT_BITS-1:0]       quotient;

   // End-of-scan decisions.
   logic                       all_black;
   logic                       left, right, all_above, all_below;
   logic [TIME_BITS-1:0]       start_eff;
   logic [TIME_BITS-1:0]       elapsed;
   logic                       black_seen_in;
   logic                       no_signal;
   logic [QUOT_BITS-1:0]       centroid;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_ACCUM;
         ST_ACCUM:    if (idx_ff == LAST_IDX) state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIVIDE;
         ST_DIVIDE:   if (div_status.done) state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      take_req  = 1'b0;
      acc_en    = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE:     take_req  = req_tvalid;
         ST_ACCUM:    acc_en    = 1'b1;
         ST_DIV_LOAD: div_start = 1'b1;
         ST_DIVIDE:   ;
         ST_FINISH:   commit    = out_free;
         default:     ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // One sensor per cycle: weight, add and compare against its threshold.
   assign cur_sample = sample_ff[idx_ff];
   assign cur_thresh = thresh_ff[idx_ff];
   assign product    = cur_sample * idx_weight(idx_ff);

   always_comb begin
      idx_in  = idx_ff;
      wsum_in = wsum_ff;
      sum_in  = sum_ff;
      if (take_req) begin
         idx_in  = '0;
         wsum_in = '0;
         sum_in  = '0;
      end else if (acc_en) begin
         idx_in  = idx_ff + 1'b1;
         wsum_in = wsum_ff + WSUM_BITS'(product);
         sum_in  = sum_ff + SUM_BITS'(cur_sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      wsum_ff <= wsum_in;
      sum_ff  <= sum_in;
      if (acc_en) begin
         above_ff[idx_ff] <= cur_sample > cur_thresh;
         below_ff[idx_ff] <= cur_sample < cur_thresh;
         black_ff[idx_ff] <= (SAMPLE_BITS+1)'(cur_sample) >
                             (SAMPLE_BITS+1)'(cur_thresh) + (SAMPLE_BITS+1)'(BLACK_OFFSET);
      end
   end

   // Capture of the scan.
   always_ff @(posedge clock) begin
      if (take_req) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            sample_ff[i] <= req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
         end
         now_ff    <= req_tdata[NOW_LSB +: TIME_BITS];
         motion_ff <= req_tdata[MOTION_BIT];
      end
   end

   // Threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            thresh_ff[i] <= THRESH_BITS'(512);
         end
      end else if (csr_we) begin
         thresh_ff[csr_addr] <= csr_wdata;
      end
   end

   lsac_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wsum_ff),
      .divisor  (sum_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   // Dwell tracking and class rules, applied once the scan is complete.
   assign all_black = &black_ff;
   assign all_above = &above_ff;
   assign all_below = &below_ff;
   assign left      = (&above_ff[7:4]) && (&below_ff[2:0]);
   assign right     = (&below_ff[7:5]) && (&above_ff[2:0]);
   assign start_eff = (all_black && !dwell_armed_ff) ? now_ff : dwell_start_ff;
   assign elapsed   = now_ff - start_eff;
   assign black_seen_in = black_seen_ff ||
                          (all_black && (elapsed >= TIME_BITS'(DWELL_MS)));
   assign no_signal = (sum_ff == '0);
   assign centroid  = no_signal ? '0 : quotient;

   always_comb begin
      class_in = class_ff;
      if (motion_ff) begin
         if (left) begin
            class_in = CLASS_LEFT;
         end else if (right) begin
            class_in = CLASS_RIGHT;
         end else if (all_below) begin
            class_in = CLASS_NOLINE;
         end else if (all_above && !black_seen_in) begin
            class_in = CLASS_TJUNCTION;
         end else begin
            class_in = CLASS_CENTRE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_armed_ff <= 1'b0;
         dwell_start_ff <= '0;
         black_seen_ff  <= 1'b0;
         class_ff       <= CLASS_CENTRE;
      end else if (commit) begin
         dwell_armed_ff <= all_black;
         dwell_start_ff <= start_eff;
         black_seen_ff  <= black_seen_in;
         class_ff       <= class_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (commit) begin
         rsp_data_ff <= RSP_DATA_BITS'({black_seen_in, class_in, no_signal, centroid});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* tb/line_sensor_array_classifier_tb.sv */
// Self-checking testbench for line_sensor_array_classifier, which it depends on
// with lsac_pkg. Drives scans and threshold writes and predicts each response
// with its own model of the centroid, dwell and class logic or a directed outcome.
module line_sensor_array_classifier_tb
   import lsac_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 130;
   localparam int PHASES         = 6;

   // One scan as it travels in req_tdata, sample_0 in the lowest bits.
   typedef struct packed {
      logic                                  motion_done;
      logic [TIME_BITS-1:0]                  now_ms;
      logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] samples;
   } scan_type;

   // One response as it travels in rsp_tdata, centroid in the lowest bits.
   typedef struct packed {
      logic           black_square;
      line_class_type line_class;
      logic           no_signal;
      logic [12:0]    centroid;
   } scan_result_type;

   typedef struct {
      scan_type        scan;
      bit              typed;
      scan_result_type want;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [IDX_BITS-1:0]      csr_addr = '0;
   logic [THRESH_BITS-1:0]   csr_wdata = '0;

   // Shadow copy of the block's thresholds and tracker state.
   logic [THRESH_BITS-1:0] thresh_shadow [SENSOR_COUNT];
   bit                     dwell_on;
   logic [TIME_BITS-1:0]   dwell_t0;
   bit                     square_seen;
   line_class_type         class_held;

   scan_result_type  expected_results [$];
   directed_row_type directed_rows [$];

   bit  sender_idles   = 1'b1;
   bit  receiver_idles = 1'b1;
   bit  hold_request   = 1'b0;
   int  mismatches     = 0;
   int  scans_sent     = 0;
   int  results_seen   = 0;
   int  settings_used  = 0;
   int  class_hits [5];
   int  idle_cycles    = 0;

   line_sensor_array_classifier uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predicts the response to one scan and advances the shadow state.
   function automatic scan_result_type predict_scan(scan_type scan);
      int unsigned     wsum;
      int unsigned     total;
      bit              all_black;
      bit              all_above;
      bit              all_below;
      bit              above [SENSOR_COUNT];
      bit              below [SENSOR_COUNT];
      bit              left_turn;
      bit              right_turn;
      logic [31:0]     elapsed;
      scan_result_type r;
      wsum = 0;
      total = 0;
      all_black = 1'b1;
      all_above = 1'b1;
      all_below = 1'b1;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         wsum += int'(scan.samples[i]) * i * POS_SCALE;
         total += int'(scan.samples[i]);
         above[i] = scan.samples[i] > thresh_shadow[i];
         below[i] = scan.samples[i] < thresh_shadow[i];
         if (!(int'(scan.samples[i]) > int'(thresh_shadow[i]) + BLACK_OFFSET))
            all_black = 1'b0;
         if (!above[i])
            all_above = 1'b0;
         if (!below[i])
            all_below = 1'b0;
      end

      // Black-square dwell: arm on the first black scan, latch after the dwell time.
      if (all_black && !dwell_on) begin
         dwell_t0 = scan.now_ms;
         dwell_on = 1'b1;
      end
      elapsed = scan.now_ms - dwell_t0;
      if (all_black && dwell_on && elapsed >= DWELL_MS)
         square_seen = 1'b1;
      if (!all_black)
         dwell_on = 1'b0;

      // The left and right rules are not mirror images of each other.
      left_turn = above[4] && above[5] && above[6] && above[7] &&
                  below[0] && below[1] && below[2];
      right_turn = below[5] && below[6] && below[7] &&
                   above[0] && above[1] && above[2];
      if (scan.motion_done) begin
         if (left_turn)
            class_held = CLASS_LEFT;
         else if (right_turn)
            class_held = CLASS_RIGHT;
         else if (all_below)
            class_held = CLASS_NOLINE;
         else if (all_above && !square_seen)
            class_held = CLASS_TJUNCTION;
         else
            class_held = CLASS_CENTRE;
      end

      r.centroid = (total != 0) ? 13'(wsum / total) : 13'd0;
      r.no_signal = (total == 0);
      r.line_class = class_held;
      r.black_square = square_seen;
      return r;
   endfunction

   function automatic scan_result_type outcome(int centroid, bit no_signal,
                                               line_class_type cls, bit black);
      scan_result_type r;
      r.centroid = 13'(centroid);
      r.no_signal = no_signal;
      r.line_class = cls;
      r.black_square = black;
      return r;
   endfunction

   function automatic void add_row(logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] samples,
                                   logic [31:0] now_ms, bit motion, bit typed,
                                   scan_result_type want);
      directed_row_type row;
      row.scan.samples = samples;
      row.scan.now_ms = now_ms;
      row.scan.motion_done = motion;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   // Sample values placed relative to a sensor's threshold.
   function automatic int above_value(int th);
      return (th >= 1023) ? 1023 : $urandom_range(1023, th + 1);
   endfunction

   function automatic int below_value(int th);
      return (th == 0) ? 0 : $urandom_range(th - 1, 0);
   endfunction

   function automatic int black_value(int th);
      return (th + BLACK_OFFSET >= 1023) ? 1023 : $urandom_range(1023, th + BLACK_OFFSET + 1);
   endfunction

   function automatic int near_value(int th);
      int v;
      case ($urandom_range(4, 0))
         0: v = th - 1;
         1: v = th;
         2: v = th + 1;
         3: v = th + BLACK_OFFSET;
         default: v = th + BLACK_OFFSET + 1;
      endcase
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return v;
   endfunction

   // Builds the samples of one scan of the given pattern kind.
   function automatic logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] scan_pattern(int kind);
      logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] s;
      int th;
      bit all_zero;
      all_zero = ($urandom_range(7, 0) == 0);
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         th = int'(thresh_shadow[i]);
         case (kind)
            2: s[i] = SAMPLE_BITS'((i <= 2) ? below_value(th)
                                   : (i >= 4) ? above_value(th) : $urandom_range(1023, 0));
            3: s[i] = SAMPLE_BITS'((i <= 2) ? above_value(th)
                                   : (i >= 5) ? below_value(th) : $urandom_range(1023, 0));
            4: s[i] = SAMPLE_BITS'(below_value(th));
            5: s[i] = SAMPLE_BITS'(above_value(th));
            6: s[i] = SAMPLE_BITS'(black_value(th));
            7: s[i] = SAMPLE_BITS'(near_value(th));
            8: s[i] = SAMPLE_BITS'((all_zero || $urandom_range(2, 0) != 0) ? 0
                                   : $urandom_range(1023, 0));
            default: s[i] = SAMPLE_BITS'($urandom_range(1023, 0));
         endcase
      end
      return s;
   endfunction

   // Offers one scan after a gap and records its expected response when it is taken.
   task automatic send_scan(scan_type scan, int gap, bit typed, scan_result_type want);
      scan_result_type predicted;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tdata <= {{(REQ_DATA_BITS - $bits(scan_type)){1'b0}}, scan};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predicted = predict_scan(scan);
      expected_results.push_back(typed ? want : predicted);
      scans_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Writes all eight thresholds on consecutive cycles while the block is idle.
   task automatic program_thresholds(int phase);
      int v;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         case (phase)
            1: v = 0;
            2: v = 1023;
            3: v = $urandom_range(700, 300);
            4: v = ($urandom_range(2, 0) == 0) ? (($urandom_range(1, 0) == 1) ? 1023 : 0)
                                               : $urandom_range(1023, 0);
            5: v = 512;
            default: v = $urandom_range(1023, 0);
         endcase
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= IDX_BITS'(i);
         csr_wdata <= THRESH_BITS'(v);
         thresh_shadow[i] = THRESH_BITS'(v);
      end
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Response side: random stalls, and one long hold-off when requested.
   initial begin
      int stall;
      forever begin
         stall = receiver_idles ? $urandom_range(19, 0) : 0;
         if (hold_request) begin
            stall = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      scan_result_type got;
      scan_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = scan_result_type'(rsp_tdata[$bits(scan_result_type)-1:0]);
         results_seen++;
         if (int'(got.line_class) < 5)
            class_hits[int'(got.line_class)]++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with no request pending: %h", rsp_tdata);
         end else begin
            exp_r = expected_results.pop_front();
            if (got.centroid !== exp_r.centroid || got.no_signal !== exp_r.no_signal ||
                got.line_class !== exp_r.line_class ||
                got.black_square !== exp_r.black_square) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: response %0d: centroid %0d/%0d no_signal %0b/%0b class %0d/%0d black %0b/%0b (expected/actual)",
                           results_seen, exp_r.centroid, got.centroid, exp_r.no_signal,
                           got.no_signal, exp_r.line_class, got.line_class,
                           exp_r.black_square, got.black_square);
            end
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles.", idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      scan_type scan;
      logic [31:0] clock_ms;
      int kind;
      int black_run;
      int gap;

      for (int i = 0; i < SENSOR_COUNT; i++)
         thresh_shadow[i] = 10'd512;
      dwell_on = 1'b0;
      dwell_t0 = '0;
      square_seen = 1'b0;
      class_held = CLASS_CENTRE;
      foreach (class_hits[i])
         class_hits[i] = 0;

      // Directed scans at the reset thresholds of 512.
      add_row('0, 32'd0, 1'b1, 1'b1, outcome(0, 1'b1, CLASS_NOLINE, 1'b0));
      add_row({8{10'd1023}}, 32'd100, 1'b0, 1'b1, outcome(3500, 1'b0, CLASS_NOLINE, 1'b0));
      // Black held 149 ms is one short of the dwell time.
      add_row({8{10'd1023}}, 32'd249, 1'b1, 1'b1, outcome(3500, 1'b0, CLASS_TJUNCTION, 1'b0));
      // Above threshold but not by more than the black offset.
      add_row({8{10'd540}}, 32'd250, 1'b1, 1'b1, outcome(3500, 1'b0, CLASS_TJUNCTION, 1'b0));
      add_row({8{10'd563}}, 32'd300, 1'b0, 1'b1, outcome(3500, 1'b0, CLASS_TJUNCTION, 1'b0));
      add_row({8{10'd1023}}, 32'd449, 1'b1, 1'b1, outcome(3500, 1'b0, CLASS_TJUNCTION, 1'b0));
      add_row('0, 32'd450, 1'b0, 1'b1, outcome(0, 1'b1, CLASS_TJUNCTION, 1'b0));
      // Dwell across the wrap of the millisecond counter.
      add_row({8{10'd1023}}, 32'hFFFF_FFB0, 1'b0, 1'b1,
              outcome(3500, 1'b0, CLASS_TJUNCTION, 1'b0));
      add_row({8{10'd1023}}, 32'h0000_0045, 1'b1, 1'b1,
              outcome(3500, 1'b0, CLASS_TJUNCTION, 1'b0));
      add_row({8{10'd1023}}, 32'h0000_0046, 1'b1, 1'b1, outcome(3500, 1'b0, CLASS_CENTRE, 1'b1));
      add_row({10'd1023, {7{10'd0}}}, 32'h50, 1'b1, 1'b1, outcome(7000, 1'b0, CLASS_CENTRE, 1'b1));
      add_row({{7{10'd0}}, 10'd1023}, 32'h51, 1'b1, 1'b1, outcome(0, 1'b0, CLASS_CENTRE, 1'b1));
      add_row({{4{10'd1023}}, {4{10'd0}}}, 32'h52, 1'b1, 1'b1,
              outcome(5500, 1'b0, CLASS_LEFT, 1'b1));
      add_row({{5{10'd0}}, {3{10'd1023}}}, 32'h53, 1'b1, 1'b1,
              outcome(1000, 1'b0, CLASS_RIGHT, 1'b1));
      // Motion not complete: the class holds.
      add_row({{4{10'd1023}}, {4{10'd0}}}, 32'h54, 1'b0, 1'b1,
              outcome(5500, 1'b0, CLASS_RIGHT, 1'b1));
      // Samples equal to the threshold are neither above nor below.
      add_row({8{10'd512}}, 32'h55, 1'b1, 1'b1, outcome(3500, 1'b0, CLASS_CENTRE, 1'b1));
      add_row({8{10'd1023}}, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
      add_row({{6{10'd0}}, 10'd1, 10'd0}, 32'h10, 1'b1, 1'b0, '0);
      add_row({10'd0, 10'd1023, {2{10'd1}}, 10'd700, 10'd0, 10'd513, 10'd511}, 32'h20,
              1'b1, 1'b0, '0);
      add_row('0, 32'h30, 1'b0, 1'b0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_scan(directed_rows[i].scan, $urandom_range(19, 0), directed_rows[i].typed,
                   directed_rows[i].want);

      // Random phases, each with its own threshold setting and idling mode.
      clock_ms = $urandom;
      black_run = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         program_thresholds(phase);
         sender_idles = (phase != 1 && phase != 4);
         receiver_idles = sender_idles;
         if (phase == 3)
            hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Black scans come in runs so that the dwell tracker gets exercised.
            if (black_run > 0) begin
               kind = 6;
               black_run--;
            end else begin
               kind = $urandom_range(9, 0);
               if (kind == 6)
                  black_run = $urandom_range(6, 1);
            end
            if ($urandom_range(49, 0) == 0)
               clock_ms = ($urandom_range(1, 0) == 1) ? $urandom : 32'hFFFF_FF80;
            else
               clock_ms += (kind == 6) ? $urandom_range(60, 0) : $urandom_range(200, 0);
            scan.samples = scan_pattern(kind);
            scan.now_ms = clock_ms;
            scan.motion_done = ($urandom_range(3, 0) != 0);
            // During the long hold-off the scans go in back to back.
            gap = (sender_idles && !(phase == 3 && n < 12)) ? $urandom_range(19, 0) : 0;
            send_scan(scan, gap, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      $display("Sent %0d scans over %0d threshold settings after the reset setting; %0d responses checked, %0d mismatches.",
               scans_sent, settings_used, results_seen, mismatches);
      $display("Classes seen: centre %0d, left %0d, right %0d, T junction %0d, no line %0d.",
               class_hits[0], class_hits[1], class_hits[2], class_hits[3], class_hits[4]);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
hdl/lsac_pkg.sv
hdl/lsac_divider.sv
hdl/line_sensor_array_classifier.sv
tb/line_sensor_array_classifier_tb.sv
